>>> design/hqm_pkg.sv
package hqm_pkg;

	// Datapath widths, fixed by the field widths of the item
	localparam int D_W        = 26;  // difference vector component
	localparam int LEN_W      = 46;  // squared length
	localparam int L_W        = 23;  // integer square root
	localparam int NUM_W      = 40;  // rounding division numerator
	localparam int Q_W        = 15;  // unit vector magnitude
	localparam int CNT_W      = 5;
	localparam int SQRT_ITERS = 23;
	localparam int DIV_ITERS  = 15;
	localparam int RD_LAST    = 4;   // five height reads in ST_RD, after the center read in ST_HC

	localparam logic [11:0] CS_RESET  = 12'd256;
	localparam logic [2:0]  SLOT_LAST = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_HC,
		ST_RD,
		ST_POS,
		ST_LOAD,
		ST_SQ,
		ST_SQRT_INIT,
		ST_SQRT,
		ST_DIV_INIT,
		ST_DIV,
		ST_DIV_ST,
		ST_CROSS_A,
		ST_CROSS_B,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_POS,
		OP_LOAD,
		OP_SQ,
		OP_SQRT_INIT,
		OP_SQRT,
		OP_DIV_INIT,
		OP_DIV,
		OP_DIV_ST,
		OP_CROSS_A,
		OP_CROSS_B,
		OP_EMIT
	} op_t;

	typedef enum logic [2:0] {
		RS_CENTER,
		RS_X,
		RS_Z,
		RS_DIAG,
		RS_NB
	} rsel_t;

	typedef enum logic [2:0] {
		CAP_NONE,
		CAP_HC,
		CAP_SUM,
		CAP_ADD,
		CAP_HN
	} cap_t;

	typedef struct packed {
		logic             rd_en;
		rsel_t            rsel;
		cap_t             cap;
		op_t              op;
		logic [CNT_W-1:0] idx;
		logic             vsel;  // 0: vector to center, 1: vector to neighbor
		logic [2:0]       slot;
	} cmd_t;

	function automatic logic corner_x(input logic [2:0] s);
		logic r;
		case (s)
			3'd1, 3'd3, 3'd4: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic corner_z(input logic [2:0] s);
		logic r;
		case (s)
			3'd2, 3'd4, 3'd5: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] nb_x(input logic [2:0] s);
		logic signed [1:0] r;
		case (s)
			3'd1, 3'd3: r = 2'sd1;
			3'd2, 3'd5: r = -2'sd1;
			default:    r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [1:0] nb_z(input logic [2:0] s);
		logic signed [1:0] r;
		case (s)
			3'd0:    r = -2'sd1;
			3'd4:    r = 2'sd1;
			default: r = 2'sd0;
		endcase
		return r;
	endfunction

	function automatic logic [1:0] next3(input logic [1:0] c);
		logic [1:0] r;
		case (c)
			2'd0:    r = 2'd1;
			2'd1:    r = 2'd2;
			default: r = 2'd0;
		endcase
		return r;
	endfunction

endpackage

>>> design/hqm_ctrl.sv
module hqm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          cmd,
	output logic          busy,
	output hqm_pkg::cmd_t dp_cmd
);

	hqm_pkg::state_t               state_q, state_d;
	logic [hqm_pkg::CNT_W-1:0]     cnt_q, cnt_d;
	logic [1:0]                    comp_q, comp_d;
	logic                          vsel_q, vsel_d;
	logic [2:0]                    slot_q, slot_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hqm_pkg::ST_IDLE;
			cnt_q   <= '0;
			comp_q  <= '0;
			vsel_q  <= 1'b0;
			slot_q  <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			comp_q  <= comp_d;
			vsel_q  <= vsel_d;
			slot_q  <= slot_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		comp_d  = comp_q;
		vsel_d  = vsel_q;
		slot_d  = slot_q;
		busy    = 1'b1;
		dp_cmd       = '0;
		dp_cmd.rsel  = hqm_pkg::RS_CENTER;
		dp_cmd.cap   = hqm_pkg::CAP_NONE;
		dp_cmd.op    = hqm_pkg::OP_NONE;
		dp_cmd.vsel  = vsel_q;
		dp_cmd.slot  = slot_q;
		unique case (state_q)
			hqm_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start && cmd) begin
					slot_d  = '0;
					state_d = hqm_pkg::ST_HC;
				end
			end
			hqm_pkg::ST_HC: begin
				dp_cmd.rd_en = 1'b1;
				dp_cmd.rsel  = hqm_pkg::RS_CENTER;
				cnt_d   = '0;
				state_d = hqm_pkg::ST_RD;
			end
			hqm_pkg::ST_RD: begin
				dp_cmd.rd_en = 1'b1;
				case (cnt_q)
					5'd0:    dp_cmd.rsel = hqm_pkg::RS_CENTER;
					5'd1:    dp_cmd.rsel = hqm_pkg::RS_X;
					5'd2:    dp_cmd.rsel = hqm_pkg::RS_Z;
					5'd3:    dp_cmd.rsel = hqm_pkg::RS_DIAG;
					default: dp_cmd.rsel = hqm_pkg::RS_NB;
				endcase
				case (cnt_q)
					5'd0:    dp_cmd.cap = hqm_pkg::CAP_HC;
					5'd1:    dp_cmd.cap = hqm_pkg::CAP_SUM;
					default: dp_cmd.cap = hqm_pkg::CAP_ADD;
				endcase
				if (cnt_q == hqm_pkg::CNT_W'(hqm_pkg::RD_LAST)) begin
					state_d = hqm_pkg::ST_POS;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			hqm_pkg::ST_POS: begin
				dp_cmd.cap = hqm_pkg::CAP_HN;
				dp_cmd.op  = hqm_pkg::OP_POS;
				vsel_d  = 1'b0;
				state_d = hqm_pkg::ST_LOAD;
			end
			hqm_pkg::ST_LOAD: begin
				dp_cmd.op = hqm_pkg::OP_LOAD;
				cnt_d   = '0;
				state_d = hqm_pkg::ST_SQ;
			end
			hqm_pkg::ST_SQ: begin
				dp_cmd.op  = hqm_pkg::OP_SQ;
				dp_cmd.idx = cnt_q;
				if (cnt_q == 5'd2) begin
					state_d = hqm_pkg::ST_SQRT_INIT;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			hqm_pkg::ST_SQRT_INIT: begin
				dp_cmd.op = hqm_pkg::OP_SQRT_INIT;
				cnt_d   = hqm_pkg::CNT_W'(hqm_pkg::SQRT_ITERS - 1);
				state_d = hqm_pkg::ST_SQRT;
			end
			hqm_pkg::ST_SQRT: begin
				dp_cmd.op  = hqm_pkg::OP_SQRT;
				dp_cmd.idx = cnt_q;
				if (cnt_q == '0) begin
					comp_d  = '0;
					state_d = hqm_pkg::ST_DIV_INIT;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			hqm_pkg::ST_DIV_INIT: begin
				dp_cmd.op  = hqm_pkg::OP_DIV_INIT;
				dp_cmd.idx = hqm_pkg::CNT_W'(comp_q);
				cnt_d   = hqm_pkg::CNT_W'(hqm_pkg::DIV_ITERS - 1);
				state_d = hqm_pkg::ST_DIV;
			end
			hqm_pkg::ST_DIV: begin
				dp_cmd.op  = hqm_pkg::OP_DIV;
				dp_cmd.idx = cnt_q;
				if (cnt_q == '0) begin
					state_d = hqm_pkg::ST_DIV_ST;
				end else begin
					cnt_d = cnt_q - 1'b1;
				end
			end
			hqm_pkg::ST_DIV_ST: begin
				dp_cmd.op  = hqm_pkg::OP_DIV_ST;
				dp_cmd.idx = hqm_pkg::CNT_W'(comp_q);
				if (comp_q != 2'd2) begin
					comp_d  = comp_q + 1'b1;
					state_d = hqm_pkg::ST_DIV_INIT;
				end else if (!vsel_q) begin
					vsel_d  = 1'b1;
					state_d = hqm_pkg::ST_LOAD;
				end else begin
					comp_d  = '0;
					state_d = hqm_pkg::ST_CROSS_A;
				end
			end
			hqm_pkg::ST_CROSS_A: begin
				dp_cmd.op  = hqm_pkg::OP_CROSS_A;
				dp_cmd.idx = hqm_pkg::CNT_W'(comp_q);
				state_d = hqm_pkg::ST_CROSS_B;
			end
			hqm_pkg::ST_CROSS_B: begin
				dp_cmd.op  = hqm_pkg::OP_CROSS_B;
				dp_cmd.idx = hqm_pkg::CNT_W'(comp_q);
				if (comp_q != 2'd2) begin
					comp_d  = comp_q + 1'b1;
					state_d = hqm_pkg::ST_CROSS_A;
				end else begin
					state_d = hqm_pkg::ST_EMIT;
				end
			end
			hqm_pkg::ST_EMIT: begin
				dp_cmd.op = hqm_pkg::OP_EMIT;
				if (slot_q == hqm_pkg::SLOT_LAST) begin
					state_d = hqm_pkg::ST_IDLE;
				end else begin
					slot_d  = slot_q + 1'b1;
					state_d = hqm_pkg::ST_HC;
				end
			end
			default: begin
				state_d = hqm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

>>> design/hqm_dpath.sv
module hqm_dpath #(
	parameter int GRID_SIZE = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  logic                cmd,
	input  logic [5:0]          grid_x,
	input  logic [5:0]          grid_z,
	input  logic signed [15:0]  sample_height,
	input  logic                cell_size_we,
	input  logic [11:0]         cell_size_wdata,
	input  hqm_pkg::cmd_t       dp_cmd,
	output logic                strobe,
	output logic signed [23:0]  pos_x,
	output logic signed [15:0]  pos_y,
	output logic signed [23:0]  pos_z,
	output logic signed [15:0]  normal_x,
	output logic signed [15:0]  normal_y,
	output logic signed [15:0]  normal_z,
	output logic [2:0]          vertex_slot,
	output logic                last
);

	localparam int DEPTH = GRID_SIZE * GRID_SIZE;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(GRID_SIZE);

	localparam int D_W   = hqm_pkg::D_W;
	localparam int LEN_W = hqm_pkg::LEN_W;
	localparam int L_W   = hqm_pkg::L_W;
	localparam int NUM_W = hqm_pkg::NUM_W;
	localparam int Q_W   = hqm_pkg::Q_W;

	// height store
	logic [15:0]   mem [DEPTH];
	logic [15:0]   rdata_q;
	logic          we;
	logic [AW-1:0] waddr, raddr;

	logic [11:0]          cs_q;
	logic [5:0]           gx_q, gz_q;
	logic signed [15:0]   hc_q, hn_q, py_q;
	logic signed [17:0]   sum_q;
	logic signed [23:0]   px_q, pz_q;
	logic signed [D_W-1:0] d_q [3];
	logic [LEN_W-1:0]     len2_q, n_q, res_q;
	logic [NUM_W-1:0]     rem_q;
	logic [Q_W-1:0]       q_q;
	logic                 neg_q;
	logic signed [15:0]   u_q [3];
	logic signed [15:0]   v_q [3];
	logic signed [31:0]   p_q;
	logic signed [15:0]   n_vec_q [3];

	function automatic logic [CW-1:0] clampc(input logic signed [7:0] c);
		logic [CW-1:0] r;
		if (c < 0) begin
			r = '0;
		end else if (int'(c) > GRID_SIZE - 1) begin
			r = CW'(GRID_SIZE - 1);
		end else begin
			r = CW'($unsigned(c));
		end
		return r;
	endfunction

	// read address: cell plus an offset chosen by the sequencer
	logic              cxb, czb;
	logic signed [1:0] ox, oz, dxo, dzo, nbx, nbz;
	logic signed [7:0] rx, rz;

	always_comb begin
		cxb = hqm_pkg::corner_x(dp_cmd.slot);
		czb = hqm_pkg::corner_z(dp_cmd.slot);
		nbx = hqm_pkg::nb_x(dp_cmd.slot);
		nbz = hqm_pkg::nb_z(dp_cmd.slot);
		dxo = cxb ? 2'sd1 : -2'sd1;
		dzo = czb ? 2'sd1 : -2'sd1;
		ox  = 2'sd0;
		oz  = 2'sd0;
		case (dp_cmd.rsel)
			hqm_pkg::RS_X:    ox = dxo;
			hqm_pkg::RS_Z:    oz = dzo;
			hqm_pkg::RS_DIAG: begin
				ox = dxo;
				oz = dzo;
			end
			hqm_pkg::RS_NB:   begin
				ox = nbx;
				oz = nbz;
			end
			default: ;
		endcase
		rx    = $signed({2'b00, gx_q}) + 8'(ox);
		rz    = $signed({2'b00, gz_q}) + 8'(oz);
		raddr = AW'(AW'(clampc(rx)) * AW'(GRID_SIZE)) + AW'(clampc(rz));
	end

	assign we    = accept && !cmd && (32'(grid_x) < GRID_SIZE) && (32'(grid_z) < GRID_SIZE);
	assign waddr = AW'(AW'(grid_x) * AW'(GRID_SIZE)) + AW'(grid_z);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= sample_height;
		end
		if (dp_cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q   <= hqm_pkg::CS_RESET;
			strobe <= 1'b0;
		end else begin
			if (cell_size_we) begin
				cs_q <= cell_size_wdata;
			end
			strobe <= (dp_cmd.op == hqm_pkg::OP_EMIT);
		end
	end

	// vertex position
	logic [6:0]          gxc, gzc;
	logic signed [8:0]   fx, fz;
	logic signed [21:0]  prx, prz;

	assign gxc = {1'b0, gx_q} + 7'(cxb);
	assign gzc = {1'b0, gz_q} + 7'(czb);
	assign fx  = $signed({1'b0, gxc, 1'b0}) - 9'sd1;
	assign fz  = $signed({1'b0, gzc, 1'b0}) - 9'sd1;
	assign prx = $signed({1'b0, cs_q}) * fx;
	assign prz = $signed({1'b0, cs_q}) * fz;

	// shared squarer
	logic signed [D_W-1:0]   sq_in;
	logic signed [2*D_W-1:0] sq_p;
	assign sq_in = d_q[dp_cmd.idx[1:0]];
	assign sq_p  = sq_in * sq_in;

	// square root step
	logic [LEN_W-1:0] sbit, strial;
	assign sbit   = LEN_W'(1) << {dp_cmd.idx, 1'b0};
	assign strial = res_q + sbit;

	// rounding division step
	logic [L_W-1:0]        root;
	logic [NUM_W-1:0]      den_sh;
	logic signed [D_W-1:0] dsel, dmag;
	logic signed [15:0]    qs;
	assign root   = res_q[L_W-1:0];
	assign den_sh = NUM_W'({root, 1'b0}) << dp_cmd.idx[3:0];
	assign dsel   = d_q[dp_cmd.idx[1:0]];
	assign dmag   = dsel[D_W-1] ? -dsel : dsel;
	assign qs     = $signed({1'b0, q_q});

	// cross product
	logic [1:0]          ci1, ci2;
	logic signed [31:0]  cp;
	logic signed [32:0]  ct;
	logic [32:0]         cmag;
	logic [19:0]         cq;
	logic signed [15:0]  csat;
	always_comb begin
		ci1  = hqm_pkg::next3(dp_cmd.idx[1:0]);
		ci2  = hqm_pkg::next3(ci1);
		if (dp_cmd.op == hqm_pkg::OP_CROSS_A) begin
			cp = u_q[ci1] * v_q[ci2];
		end else begin
			cp = u_q[ci2] * v_q[ci1];
		end
		ct   = 33'(p_q) - 33'(cp);
		cmag = ct[32] ? $unsigned(-ct) : $unsigned(ct);
		cq   = 20'((cmag + 33'd8192) >> 14);
		if (ct[32]) begin
			csat = (cq > 20'd32768) ? -16'sd32768 : 16'(-$signed(cq));
		end else begin
			csat = (cq > 20'd32767) ? 16'sd32767 : 16'(cq);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gx_q <= grid_x;
			gz_q <= grid_z;
		end
		case (dp_cmd.cap)
			hqm_pkg::CAP_HC:  hc_q  <= rdata_q;
			hqm_pkg::CAP_SUM: sum_q <= 18'($signed(rdata_q));
			hqm_pkg::CAP_ADD: sum_q <= sum_q + 18'($signed(rdata_q));
			hqm_pkg::CAP_HN:  hn_q  <= rdata_q;
			default: ;
		endcase
		case (dp_cmd.op)
			hqm_pkg::OP_POS: begin
				px_q <= 24'(prx >>> 1);
				pz_q <= 24'(prz >>> 1);
				py_q <= 16'(sum_q >>> 2);
			end
			hqm_pkg::OP_LOAD: begin
				if (!dp_cmd.vsel) begin
					d_q[0] <= $signed({8'b0, gx_q, 12'b0}) - (D_W'(px_q) <<< 4);
					d_q[1] <= D_W'(hc_q) - D_W'(py_q);
					d_q[2] <= $signed({8'b0, gz_q, 12'b0}) - (D_W'(pz_q) <<< 4);
				end else begin
					d_q[0] <= -(D_W'(nbx) <<< 12);
					d_q[1] <= D_W'(hc_q) - D_W'(hn_q);
					d_q[2] <= -(D_W'(nbz) <<< 12);
				end
			end
			hqm_pkg::OP_SQ: begin
				len2_q <= ((dp_cmd.idx == '0) ? '0 : len2_q) + LEN_W'(sq_p);
			end
			hqm_pkg::OP_SQRT_INIT: begin
				n_q   <= len2_q;
				res_q <= '0;
			end
			hqm_pkg::OP_SQRT: begin
				if (n_q >= strial) begin
					n_q   <= n_q - strial;
					res_q <= (res_q >> 1) + sbit;
				end else begin
					res_q <= res_q >> 1;
				end
			end
			hqm_pkg::OP_DIV_INIT: begin
				rem_q <= (NUM_W'($unsigned(dmag)) << 15) + NUM_W'(root);
				q_q   <= '0;
				neg_q <= dsel[D_W-1];
			end
			hqm_pkg::OP_DIV: begin
				if (rem_q >= den_sh) begin
					rem_q <= rem_q - den_sh;
					q_q   <= q_q | (Q_W'(1) << dp_cmd.idx[3:0]);
				end
			end
			hqm_pkg::OP_DIV_ST: begin
				if (!dp_cmd.vsel) begin
					u_q[dp_cmd.idx[1:0]] <= (root == '0) ? 16'sd0 : (neg_q ? -qs : qs);
				end else begin
					v_q[dp_cmd.idx[1:0]] <= (root == '0) ? 16'sd0 : (neg_q ? -qs : qs);
				end
			end
			hqm_pkg::OP_CROSS_A: begin
				p_q <= cp;
			end
			hqm_pkg::OP_CROSS_B: begin
				n_vec_q[dp_cmd.idx[1:0]] <= csat;
			end
			hqm_pkg::OP_EMIT: begin
				pos_x       <= px_q;
				pos_y       <= py_q;
				pos_z       <= pz_q;
				normal_x    <= n_vec_q[0];
				normal_y    <= n_vec_q[1];
				normal_z    <= n_vec_q[2];
				vertex_slot <= dp_cmd.slot;
				last        <= (dp_cmd.slot == hqm_pkg::SLOT_LAST);
			end
			default: ;
		endcase
	end

endmodule

>>> design/heightmap_quad_mesh_generator_core.sv
// Heightmap quad mesh generator.
// Input: raise start with cmd, grid_x, grid_z, sample_height; the item is
// taken on a rising edge where start is high and busy is low.
//  - cmd 0 writes sample_height into the height store at (grid_x, grid_z)
//    in the accept cycle; busy never rises, so writes go back to back.
//    Writes outside the GRID_SIZE x GRID_SIZE grid are dropped.
//  - cmd 1 generates one quad: six vertices, slots 0..5, last on slot 5.
// Output: each vertex appears on the result ports with strobe high for one
// cycle; the ports hold it until the next vertex. The receiver cannot stall, so nothing waits on it.
// Config: cell_size_we / cell_size_wdata write cell_size (Q4.8, reset 256); the user
// writes it only while the block is idle, which the block itself does not enforce.
// Sequence: each vertex runs through the sequencer: height reads and
// position math, then two normalizations (3 squares, a 23-step square
// root, 3 divisions on one shared divider), a cross product and an emit.
// A quad holds busy from the accept edge until its last vertex is emitted.
// Reset clears the controller and sets cell_size; the height store holds
// garbage until written.
module heightmap_quad_mesh_generator_core #(
	parameter int GRID_SIZE = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               cmd,
	input  logic [5:0]         grid_x,
	input  logic [5:0]         grid_z,
	input  logic signed [15:0] sample_height,
	input  logic               cell_size_we,
	input  logic [11:0]        cell_size_wdata,
	output logic               strobe,
	output logic signed [23:0] pos_x,
	output logic signed [15:0] pos_y,
	output logic signed [23:0] pos_z,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [2:0]         vertex_slot,
	output logic               last
);

	hqm_pkg::cmd_t dp_cmd;
	logic          accept;

	// item handshake
	assign accept = start && !busy;

	// sequencer: owns slot, iteration and component counters
	hqm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.dp_cmd (dp_cmd)
	);

	// height store, squarer, root and divider units, output registers
	hqm_dpath #(
		.GRID_SIZE (GRID_SIZE)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.accept          (accept),
		.cmd             (cmd),
		.grid_x          (grid_x),
		.grid_z          (grid_z),
		.sample_height   (sample_height),
		.cell_size_we    (cell_size_we),
		.cell_size_wdata (cell_size_wdata),
		.dp_cmd          (dp_cmd),
		.strobe          (strobe),
		.pos_x           (pos_x),
		.pos_y           (pos_y),
		.pos_z           (pos_z),
		.normal_x        (normal_x),
		.normal_y        (normal_y),
		.normal_z        (normal_z),
		.vertex_slot     (vertex_slot),
		.last            (last)
	);

	// a vertex only comes out of a quad in flight
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("vertex strobe without a quad in flight");

	// last marks slot five
	a_last_slot: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> vertex_slot == hqm_pkg::SLOT_LAST)
		else $error("last on a vertex other than slot five");

	// quad still running after any vertex but the last
	a_mid_quad: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |-> busy)
		else $error("quad dropped before its last vertex");

	// writes never take the block busy
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !cmd |=> !busy)
		else $error("height write made the block busy");

endmodule
